>>> sv/priority_led_pattern_engine_top_macros.svh
// assertion macros for the priority led pattern engine
`ifndef PRIORITY_LED_PATTERN_ENGINE_TOP_MACROS_SVH
`define PRIORITY_LED_PATTERN_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define PLPE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// checked during reset too
`define PLPE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define PLPE_ASSERT(lbl, prop, msg)
`define PLPE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> sv/plpe_pkg.sv
// shared types, constants and tables of the priority led pattern engine
`default_nettype none
package plpe_pkg;

    localparam int SLOT_COUNT = 4;
    localparam int SLOT_IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int OWN_W      = $clog2(SLOT_COUNT + 1);
    localparam int GUARD      = 2 * SLOT_COUNT + 4;
    localparam int PASS_W     = $clog2(GUARD + 1);
    localparam int ADDR_W     = 5;

    localparam logic [13:0] PPTT  = 14'd10000;
    // floor(x / 10000) as (x * RECIP) >> RECIP_SH, exact for x below 2^28
    localparam logic [26:0] RECIP    = 27'd109951163;
    localparam int          RECIP_SH = 40;

    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_SET  = 2'd1;
    localparam logic [1:0] REQ_SHUT = 2'd2;

    localparam logic [4:0] PAT_OFF      = 5'd0;
    localparam logic [4:0] PAT_FORCED   = 5'd1;
    localparam logic [4:0] PAT_ON       = 5'd2;
    localparam logic [4:0] PAT_DIM      = 5'd3;
    localparam logic [4:0] PAT_SHORT    = 5'd4;
    localparam logic [4:0] PAT_LONG     = 5'd5;
    localparam logic [4:0] PAT_FLASH    = 5'd6;
    localparam logic [4:0] PAT_DFU      = 5'd7;
    localparam logic [4:0] PAT_POWERON  = 5'd8;
    localparam logic [4:0] PAT_PROGRESS = 5'd9;
    localparam logic [4:0] PAT_COMPLETE = 5'd10;
    localparam logic [4:0] PAT_PING     = 5'd11;
    localparam logic [4:0] PAT_POWEROFF = 5'd12;
    localparam logic [4:0] PAT_ERR_A    = 5'd13;
    localparam logic [4:0] PAT_ERR_D    = 5'd16;

    localparam logic [2:0] COL_DEFAULT  = 3'd0;
    localparam logic [2:0] COL_SUCCESS  = 3'd1;
    localparam logic [2:0] COL_ERROR    = 3'd2;
    localparam logic [2:0] COL_CHARGING = 3'd3;
    localparam logic [2:0] COL_PAIRING  = 3'd4;

    localparam logic [2:0] REG_GB     = 3'd0;
    localparam logic [2:0] REG_RED    = 3'd1;
    localparam logic [2:0] REG_GREEN  = 3'd2;
    localparam logic [2:0] REG_BLUE   = 3'd3;
    localparam logic [2:0] REG_PERIOD = 3'd4;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] slot;
        logic [4:0] pattern;
    } in_t;

    typedef struct packed {
        logic [15:0] duty_red;
        logic [15:0] duty_green;
        logic [15:0] duty_blue;
        logic        led_powered;
        logic [4:0]  shown_pattern;
        logic [2:0]  shown_slot;
    } out_t;

    typedef struct packed {
        logic       load;
        logic       eval;
        logic       render;
        logic       mul_gb;
        logic       div_gb;
        logic       mul_ch;
        logic       div_ch;
        logic       fin;
        logic       out_load;
        logic [1:0] chan;
    } cmd_t;

    typedef struct packed {
        logic eval_stop;
        logic render_done;
        logic out_busy;
    } status_t;

    // fixed colour rows, channel 0 red, 1 green, 2 blue
    function automatic logic [13:0] colour_share(input logic [2:0] colour,
                                                 input logic [1:0] chan);
        logic [13:0] r;
        r = 14'd0;
        case (colour)
            COL_SUCCESS:  r = (chan == 2'd1) ? 14'd10000 : 14'd0;
            COL_ERROR:    r = (chan == 2'd0) ? 14'd10000 : 14'd0;
            COL_CHARGING: r = (chan == 2'd0) ? 14'd8000 : ((chan == 2'd1) ? 14'd2000 : 14'd0);
            COL_PAIRING:  r = (chan == 2'd2) ? 14'd10000 : 14'd0;
            default:      r = 14'd0;
        endcase
        return r;
    endfunction

    function automatic logic [13:0] sat_pptt(input logic [13:0] v);
        return (v > PPTT) ? PPTT : v;
    endfunction

endpackage
`default_nettype wire

>>> sv/priority_led_pattern_engine_top.sv
// top level of the priority led pattern engine
// channel   direction  ports                     payload
// request   in         s_valid s_ready s_data    req_type slot pattern
// result    out        m_valid m_ready m_data    duties, power, pattern, slot
// config    in         apb psel..pready          five registers at 4*i
// a request steps through load and evaluate, then, for each rendered frame, render,
// global scale and three channel scales through the shared multiply and
// reciprocal divide, then finish; each further pass after a finished one-shot
// evaluates the next winner, at most 12 passes
// reset clears slots, sequencer state and config to defaults, no clearing pass
// a waiting result does not block the next request; only the hand-off of a
// finished request waits while the output register is still full
`default_nettype none
`include "priority_led_pattern_engine_top_macros.svh"
module priority_led_pattern_engine_top
    import plpe_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_t               s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_t                   m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    cmd_t    cmd;
    status_t status;

    assign pready = 1'b1;

    plpe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    plpe_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata)
    );

    `PLPE_ASSERT(a_busy_after_req, (s_valid && s_ready) |=> !s_ready, "request did not start work")
    `PLPE_ASSERT(a_valid_from_load, $rose(m_valid) |-> $past(cmd.out_load), "result without load")
    `PLPE_ASSERT(a_dark_zero, (m_valid && !m_data.led_powered) |-> ((m_data.duty_red == 16'd0) && (m_data.duty_green == 16'd0) && (m_data.duty_blue == 16'd0)), "unpowered led has duty")
    `PLPE_ASSERT_ALWAYS(a_no_cmd_overlap, $onehot0({cmd.load, cmd.eval, cmd.render, cmd.mul_gb, cmd.div_gb, cmd.mul_ch, cmd.div_ch, cmd.fin, cmd.out_load}), "overlapping commands")

endmodule
`default_nettype wire

>>> sv/plpe_ctrl.sv
// controller state machine of the priority led pattern engine
`default_nettype none
module plpe_ctrl
    import plpe_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_EVAL = 9'b000000010,
        S_REND = 9'b000000100,
        S_MGB  = 9'b000001000,
        S_DGB  = 9'b000010000,
        S_MCH  = 9'b000100000,
        S_DCH  = 9'b001000000,
        S_FIN  = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic [1:0]        chan_reg, chan_next;

    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        chan_next  = chan_reg;
        cmd        = '0;
        cmd.chan   = chan_reg;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    pass_next  = '0;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval  = 1'b1;
                pass_next = pass_reg + 1'b1;
                state_next = status.eval_stop ? S_OUT : S_REND;
            end
            S_REND: begin
                cmd.render = 1'b1;
                state_next = S_MGB;
            end
            S_MGB: begin
                cmd.mul_gb = 1'b1;
                state_next = S_DGB;
            end
            S_DGB: begin
                cmd.div_gb = 1'b1;
                chan_next  = 2'd0;
                state_next = S_MCH;
            end
            S_MCH: begin
                cmd.mul_ch = 1'b1;
                state_next = S_DCH;
            end
            S_DCH: begin
                cmd.div_ch = 1'b1;
                chan_next  = chan_reg + 2'd1;
                state_next = (chan_reg == 2'd2) ? S_FIN : S_MCH;
            end
            S_FIN: begin
                cmd.fin = 1'b1;
                // a finished one-shot hands over to the next winner
                if (status.render_done && (32'(pass_reg) < GUARD)) begin
                    state_next = S_EVAL;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pass_reg  <= '0;
            chan_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            chan_reg  <= chan_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/plpe_datapath.sv
// slot table, pattern sequencer state, duty arithmetic and config registers
`default_nettype none
module plpe_datapath
    import plpe_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cmd_t              cmd,
    output status_t                status,
    input  wire in_t               s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_t                   m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata
);

    logic [13:0] gb_reg, red_reg, green_reg, blue_reg;
    logic [15:0] period_reg;

    logic [4:0]       slot_pat_reg [SLOT_COUNT];
    logic [7:0]       slot_ver_reg [SLOT_COUNT];
    logic [4:0]       act_pat_reg;
    logic [OWN_W-1:0] act_own_reg;
    logic [7:0]       act_ver_reg;
    logic [7:0]       frame_reg;
    logic [7:0]       ticks_reg;
    logic             hold_reg;
    logic             power_reg;
    logic [15:0]      drive_reg [3];
    logic             skip_reg;
    logic [13:0]      level_reg;
    logic [2:0]       colour_reg;
    logic             done_reg;
    logic [4:0]       left_reg;
    logic [27:0]      prod_reg;
    logic             m_valid_reg;
    out_t             m_data_reg;

    // winner search over the slot table
    logic [OWN_W-1:0] win_idx;
    logic [4:0]       win_pat;
    logic [7:0]       win_ver;
    logic             found;
    logic             restart;
    logic             hold_eff;
    logic [7:0]       ticks_eff;

    always_comb begin
        win_idx = OWN_W'(SLOT_COUNT);
        win_pat = PAT_OFF;
        win_ver = 8'd0;
        found   = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!found && slot_pat_reg[i] != PAT_OFF) begin
                found   = 1'b1;
                win_idx = OWN_W'(i);
                win_pat = slot_pat_reg[i];
                win_ver = slot_ver_reg[i];
            end
        end
        restart   = (win_pat != act_pat_reg) ||
                    ((win_idx == act_own_reg) && (win_ver != act_ver_reg));
        hold_eff  = restart ? 1'b0 : hold_reg;
        ticks_eff = restart ? 8'd0 : ticks_reg;
    end

    // frame parameters of the active pattern
    logic [8:0]  frame1;
    logic [8:0]  err_lim;
    logic [8:0]  err_s;
    logic [4:0]  err_thr;
    logic [8:0]  fade_k;
    logic [2:0]  r_colour;
    logic [13:0] r_bright;
    logic        r_value;
    logic [7:0]  r_wait;
    logic        r_forever;
    logic        r_done;
    logic [4:0]  r_left;
    logic [7:0]  r_s;

    always_comb begin
        frame1    = {1'b0, frame_reg} + 9'd1;
        err_lim   = (act_pat_reg == PAT_ERR_D) ? 9'd2 : 9'd10;
        err_s     = (frame1 >= err_lim) ? (frame1 - err_lim) : frame1;
        err_thr   = 5'd4 + 5'((act_pat_reg - PAT_ERR_A) << 1);
        fade_k    = 9'd202 - frame1;
        r_colour  = COL_DEFAULT;
        r_bright  = PPTT;
        r_value   = 1'b0;
        r_wait    = 8'd0;
        r_forever = 1'b0;
        r_done    = 1'b0;
        r_left    = PAT_OFF;
        r_s       = frame_reg;
        if (act_pat_reg == PAT_ON || act_pat_reg == PAT_DIM) begin
            r_colour  = (act_pat_reg == PAT_ON) ? COL_DEFAULT : COL_SUCCESS;
            r_bright  = (act_pat_reg == PAT_ON) ? PPTT : 14'd2000;
            r_value   = 1'b1;
            r_forever = 1'b1;
        end else if (act_pat_reg >= PAT_SHORT && act_pat_reg <= PAT_DFU) begin
            r_s     = {7'd0, ~frame_reg[0]};
            r_value = ~frame_reg[0];
            r_colour = (act_pat_reg == PAT_SHORT) ? COL_PAIRING :
                       ((act_pat_reg == PAT_DFU) ? COL_CHARGING : COL_DEFAULT);
            case (act_pat_reg)
                PAT_SHORT: r_wait = (~frame_reg[0]) ? 8'd20 : 8'd180;
                PAT_LONG:  r_wait = 8'd100;
                PAT_FLASH: r_wait = 8'd40;
                default:   r_wait = 8'd20;
            endcase
        end else if (act_pat_reg >= PAT_POWERON && act_pat_reg <= PAT_PING) begin
            r_s      = frame1[7:0];
            r_colour = (act_pat_reg == PAT_PROGRESS || act_pat_reg == PAT_COMPLETE) ?
                       COL_SUCCESS : COL_DEFAULT;
            r_value  = (act_pat_reg == PAT_PING) ? frame1[0] : ~frame1[0];
            case (act_pat_reg)
                PAT_POWERON:  r_done = (frame1 == 9'd7);
                PAT_PROGRESS: r_done = (frame1 == 9'd5);
                PAT_COMPLETE: r_done = (frame1 == 9'd9);
                default:      r_done = (frame1 == 9'd20);
            endcase
            r_wait = 8'd40;
        end else if (act_pat_reg == PAT_POWEROFF) begin
            r_s = frame1[7:0];
            if (frame1 == 9'd1) begin
                r_bright = PPTT;
            end else if (frame1 <= 9'd202) begin
                r_bright = 14'(fade_k) * 14'd50;
            end else begin
                r_bright = 14'd0;
            end
            r_value = !(frame1 == 9'd1 || frame1 >= 9'd202);
            r_wait  = (frame1 == 9'd1) ? 8'd50 : 8'd1;
            r_done  = (frame1 >= 9'd202);
            r_left  = PAT_FORCED;
        end else if (act_pat_reg >= PAT_ERR_A && act_pat_reg <= PAT_ERR_D) begin
            r_colour = COL_ERROR;
            r_s      = err_s[7:0];
            r_value  = err_s[0] && ((act_pat_reg == PAT_ERR_D) || (err_s < 9'(err_thr)));
            r_wait   = 8'd100;
        end else begin
            r_forever = 1'b1;
        end
    end

    // shared scale arithmetic
    logic [54:0] recip_prod;
    logic [13:0] quot;
    logic [2:0]  pdiv;
    logic [13:0] share;
    logic [16:0] duty_full;
    logic [SLOT_IW-1:0] own_idx;
    logic [SLOT_IW-1:0] set_idx;

    always_comb begin
        recip_prod = 55'(prod_reg) * 55'(RECIP);
        quot       = 14'(recip_prod >> RECIP_SH);
        if (period_reg >= 16'd60000) begin
            pdiv = 3'd6;
        end else if (period_reg >= 16'd50000) begin
            pdiv = 3'd5;
        end else if (period_reg >= 16'd40000) begin
            pdiv = 3'd4;
        end else if (period_reg >= 16'd30000) begin
            pdiv = 3'd3;
        end else if (period_reg >= 16'd20000) begin
            pdiv = 3'd2;
        end else if (period_reg >= 16'd10000) begin
            pdiv = 3'd1;
        end else begin
            pdiv = 3'd0;
        end
        if (colour_reg == COL_DEFAULT) begin
            case (cmd.chan)
                2'd0:    share = sat_pptt(red_reg);
                2'd1:    share = sat_pptt(green_reg);
                default: share = sat_pptt(blue_reg);
            endcase
        end else begin
            share = colour_share(colour_reg, cmd.chan);
        end
        duty_full = 17'(pdiv) * 17'(quot);
        own_idx   = SLOT_IW'(act_own_reg);
        set_idx   = SLOT_IW'(s_data.slot);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gb_reg      <= 14'd10000;
            red_reg     <= 14'd0;
            green_reg   <= 14'd0;
            blue_reg    <= 14'd10000;
            period_reg  <= 16'd20000;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_pat_reg[i] <= PAT_OFF;
                slot_ver_reg[i] <= 8'd0;
            end
            act_pat_reg <= PAT_OFF;
            act_own_reg <= OWN_W'(SLOT_COUNT);
            act_ver_reg <= 8'd0;
            frame_reg   <= 8'd0;
            ticks_reg   <= 8'd0;
            hold_reg    <= 1'b0;
            power_reg   <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                drive_reg[k] <= 16'd0;
            end
            skip_reg    <= 1'b0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                case (paddr[4:2])
                    REG_GB:     gb_reg     <= pwdata[13:0];
                    REG_RED:    red_reg    <= pwdata[13:0];
                    REG_GREEN:  green_reg  <= pwdata[13:0];
                    REG_BLUE:   blue_reg   <= pwdata[13:0];
                    REG_PERIOD: period_reg <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (cmd.load) begin
                skip_reg <= 1'b0;
                case (s_data.req_type)
                    REQ_TICK: begin
                        if (ticks_reg != 8'd0) begin
                            ticks_reg <= ticks_reg - 8'd1;
                        end
                    end
                    REQ_SET: begin
                        if ((32'(s_data.slot) < SLOT_COUNT) &&
                            (slot_pat_reg[set_idx] != s_data.pattern)) begin
                            slot_pat_reg[set_idx] <= s_data.pattern;
                            slot_ver_reg[set_idx] <= slot_ver_reg[set_idx] + 8'd1;
                        end
                    end
                    REQ_SHUT: begin
                        for (int k = 0; k < 3; k++) begin
                            drive_reg[k] <= 16'd0;
                        end
                        power_reg       <= 1'b0;
                        slot_pat_reg[0] <= PAT_FORCED;
                        slot_ver_reg[0] <= slot_ver_reg[0] + 8'd1;
                    end
                    default: skip_reg <= 1'b1;
                endcase
            end
            if (cmd.eval && !skip_reg) begin
                if (restart) begin
                    act_pat_reg <= win_pat;
                    frame_reg   <= 8'd0;
                    ticks_reg   <= 8'd0;
                    hold_reg    <= 1'b0;
                end
                act_own_reg <= win_idx;
                act_ver_reg <= win_ver;
                if (win_pat <= PAT_FORCED) begin
                    if (power_reg) begin
                        for (int k = 0; k < 3; k++) begin
                            drive_reg[k] <= 16'd0;
                        end
                        power_reg <= 1'b0;
                    end
                end else begin
                    power_reg <= 1'b1;
                end
            end
            if (cmd.render) begin
                frame_reg <= r_s;
                done_reg  <= r_done;
                if (!r_done) begin
                    if (r_forever) begin
                        hold_reg <= 1'b1;
                    end else begin
                        ticks_reg <= r_wait;
                    end
                end
            end
            if (cmd.div_ch) begin
                drive_reg[cmd.chan] <= duty_full[15:0];
            end
            if (cmd.fin && done_reg) begin
                slot_pat_reg[own_idx] <= left_reg;
                slot_ver_reg[own_idx] <= slot_ver_reg[own_idx] + 8'd1;
                frame_reg <= 8'd0;
                ticks_reg <= 8'd0;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.render) begin
            level_reg  <= r_value ? r_bright : 14'd0;
            colour_reg <= r_colour;
            left_reg   <= r_left;
        end
        if (cmd.mul_gb) begin
            prod_reg <= 28'(level_reg) * 28'(sat_pptt(gb_reg));
        end
        if (cmd.div_gb) begin
            level_reg <= quot;
        end
        if (cmd.mul_ch) begin
            prod_reg <= 28'(share) * 28'(level_reg);
        end
        if (cmd.out_load) begin
            m_data_reg.duty_red      <= drive_reg[0];
            m_data_reg.duty_green    <= drive_reg[1];
            m_data_reg.duty_blue     <= drive_reg[2];
            m_data_reg.led_powered   <= power_reg;
            m_data_reg.shown_pattern <= act_pat_reg;
            m_data_reg.shown_slot    <= 3'(act_own_reg);
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_GB:     prdata = 32'(gb_reg);
            REG_RED:    prdata = 32'(red_reg);
            REG_GREEN:  prdata = 32'(green_reg);
            REG_BLUE:   prdata = 32'(blue_reg);
            REG_PERIOD: prdata = 32'(period_reg);
            default:    prdata = 32'd0;
        endcase
    end

    assign status.eval_stop   = skip_reg || (win_pat <= PAT_FORCED) || hold_eff ||
                                (ticks_eff != 8'd0);
    assign status.render_done = done_reg;
    assign status.out_busy    = m_valid_reg && !m_ready;
    assign m_valid            = m_valid_reg;
    assign m_data             = m_data_reg;

endmodule
`default_nettype wire
